/* hw/rtl/wall_column_rasterizer_zbuf_unit_assert.svh */
// Assertion helpers for the wall column rasterizer.
// Both check on the rising edge of clk_i and stay quiet while rst_ni is low.
`ifndef WALL_COLUMN_RASTERIZER_ZBUF_UNIT_ASSERT_SVH
`define WALL_COLUMN_RASTERIZER_ZBUF_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define WCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define WCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/wcr_pkg.sv */
`default_nettype none
package wcr_pkg;

  // Command modes
  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_PEN   = 2'd1,
    MODE_DRAW  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  wall_color;
    logic [15:0] vert_x;
    logic [15:0] vert_top;
    logic [15:0] vert_bottom;
    logic [15:0] vert_depth;
  } cmd_t;

  typedef struct packed {
    logic [5:0] column;
    logic [5:0] top_row;
    logic [5:0] bottom_row;
    logic [1:0] span_color;
    logic       last;
  } res_t;

  // Work handed from the front to the back
  typedef struct packed {
    logic        clear;
    logic [1:0]  color;
    logic        dir_neg;
    logic [15:0] x;
    logic [15:0] yt;
    logic [15:0] yb;
    logic [15:0] z;
    logic [15:0] mt;
    logic [15:0] mb;
    logic [15:0] mz;
    logic [15:0] vx;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_LAUNCH,
    F_WAIT,
    F_PUSH
  } front_st_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_GUARD,
    B_COL,
    B_CMP,
    B_END
  } back_st_e;

  localparam int          DIV_W      = 24;
  localparam int          Q_DEPTH    = 2;
  localparam logic [15:0] STEP_POS   = 16'h0100;
  localparam logic [15:0] STEP_NEG   = 16'hFF00;
  localparam logic [15:0] DEPTH_INIT = 16'hFFFF;

endpackage
`default_nettype wire

/* hw/rtl/wcr_ram.sv */
`default_nettype none
module wcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* hw/rtl/wcr_div.sv */
`default_nettype none
module wcr_div
  import wcr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [15:0]      divisor_i,
  output logic                  done_o,
  output logic [DIV_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [15:0]      rem_q;
  logic [15:0]      div_q;
  logic [DIV_W-1:0] quo_q;

  logic [16:0] rem_sh;
  logic [16:0] diff;
  logic        ge;

  // One restoring step: shift in the next dividend bit, trial subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    diff   = rem_sh - {1'b0, div_q};
    ge     = rem_sh >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[15:0] : rem_sh[15:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

/* hw/rtl/wcr_fifo.sv */
`default_nettype none
module wcr_fifo
  import wcr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t data_i,
  input  wire logic pop_i,
  output job_t      data_o,
  output fifo_stat_t stat_o
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  job_t             mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_q;
  logic [PTR_W-1:0] rd_q;
  logic [PTR_W:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == (PTR_W+1)'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule
`default_nettype wire

/* hw/rtl/wcr_front.sv */
`default_nettype none
module wcr_front
  import wcr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire cmd_t             cmd_i,
  output logic                  busy_o,
  input  wire fifo_stat_t       qstat_i,
  output logic                  push_o,
  output job_t                  job_o,
  output logic                  div_start_o,
  output logic [DIV_W-1:0]      div_dividend_o,
  output logic [15:0]           div_divisor_o,
  input  wire logic             div_done_i,
  input  wire logic [DIV_W-1:0] div_quot_i
);

  front_st_e   st_q, st_d;
  logic [15:0] pen_x_q, pen_top_q, pen_bottom_q, pen_depth_q;
  job_t        job_q;
  logic [15:0] dmag_q [3];
  logic [2:0]  dneg_q;
  logic [15:0] adx_q;
  logic [1:0]  sel_q;

  logic        accept;
  logic [15:0] dx, dt, db, dz, adx;
  logic        dx_zero;
  logic [15:0] slope;

  // Differences against the pen and their magnitudes
  always_comb begin
    accept  = start_i && !busy_o;
    dx      = cmd_i.vert_x - pen_x_q;
    dt      = cmd_i.vert_top - pen_top_q;
    db      = cmd_i.vert_bottom - pen_bottom_q;
    dz      = cmd_i.vert_depth - pen_depth_q;
    adx     = dx[15] ? (16'd0 - dx) : dx;
    dx_zero = (dx == 16'd0);
    slope   = dneg_q[sel_q] ? (16'd0 - div_quot_i[15:0]) : div_quot_i[15:0];
  end

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      F_IDLE: begin
        if (accept && cmd_i.mode == MODE_DRAW && !dx_zero) begin
          st_d = F_LAUNCH;
        end
      end
      F_LAUNCH: st_d = F_WAIT;
      F_WAIT: begin
        if (div_done_i) begin
          st_d = (sel_q == 2'd2) ? F_PUSH : F_LAUNCH;
        end
      end
      F_PUSH: begin
        if (!qstat_i.full) begin
          st_d = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy_o         = (st_q != F_IDLE) || qstat_i.full;
    push_o         = 1'b0;
    job_o          = job_q;
    job_o.clear    = (st_q == F_IDLE);
    div_start_o    = (st_q == F_LAUNCH);
    div_dividend_o = {dmag_q[sel_q], 8'h00};
    div_divisor_o  = adx_q;
    case (st_q)
      F_IDLE:  push_o = accept && (cmd_i.mode == MODE_CLEAR);
      F_PUSH:  push_o = !qstat_i.full;
      default: push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= F_IDLE;
      sel_q        <= '0;
      pen_x_q      <= '0;
      pen_top_q    <= '0;
      pen_bottom_q <= '0;
      pen_depth_q  <= '0;
    end else begin
      st_q <= st_d;
      // pen moves on a pen command or a draw with nonzero dx
      if (accept && (cmd_i.mode == MODE_PEN ||
                     (cmd_i.mode == MODE_DRAW && !dx_zero))) begin
        pen_x_q      <= cmd_i.vert_x;
        pen_top_q    <= cmd_i.vert_top;
        pen_bottom_q <= cmd_i.vert_bottom;
        pen_depth_q  <= cmd_i.vert_depth;
      end
      if (st_q == F_IDLE) begin
        sel_q <= '0;
      end else if (st_q == F_WAIT && div_done_i) begin
        sel_q <= sel_q + 1'b1;
      end
    end
  end

  // Draw setup and slope capture
  always_ff @(posedge clk_i) begin
    if (st_q == F_IDLE && accept && cmd_i.mode == MODE_DRAW && !dx_zero) begin
      job_q.color   <= cmd_i.wall_color;
      job_q.dir_neg <= dx[15];
      job_q.x       <= pen_x_q;
      job_q.yt      <= pen_top_q;
      job_q.yb      <= pen_bottom_q;
      job_q.z       <= pen_depth_q;
      job_q.vx      <= cmd_i.vert_x;
      dmag_q[0]     <= dt[15] ? (16'd0 - dt) : dt;
      dmag_q[1]     <= db[15] ? (16'd0 - db) : db;
      dmag_q[2]     <= dz[15] ? (16'd0 - dz) : dz;
      dneg_q        <= {dz[15], db[15], dt[15]};
      adx_q         <= adx;
    end
    if (st_q == F_WAIT && div_done_i) begin
      case (sel_q)
        2'd0:    job_q.mt <= slope;
        2'd1:    job_q.mb <= slope;
        default: job_q.mz <= slope;
      endcase
    end
    job_q.clear <= 1'b0;
  end

endmodule
`default_nettype wire

/* hw/rtl/wcr_back.sv */
`default_nettype none
module wcr_back
  import wcr_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 64,
  parameter int SCREEN_ROWS    = 60,
  parameter int GUARD_OFFSET   = 16384
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire fifo_stat_t qstat_i,
  input  wire job_t       job_i,
  output logic            pop_o,
  output res_t            result_o,
  output logic            result_strobe_o
);

  localparam int          CW     = $clog2(SCREEN_COLUMNS);
  localparam logic [16:0] X_LO   = 17'(GUARD_OFFSET);
  localparam logic [16:0] X_HI   = 17'(SCREEN_COLUMNS * 256 + GUARD_OFFSET);
  localparam logic [15:0] LO16   = 16'(GUARD_OFFSET);
  localparam logic [17:0] Y_LO   = 18'(GUARD_OFFSET);
  localparam logic [17:0] Y_HI   = 18'(SCREEN_ROWS * 256 + GUARD_OFFSET);
  localparam logic [8:0]  NCOL   = 9'(SCREEN_COLUMNS);
  localparam logic [5:0]  ROW_MX = 6'(SCREEN_ROWS);

  back_st_e              st_q, st_d;
  logic [15:0]           x_q, x_d, tx_q, tx_d;
  logic [15:0]           yt_q, yt_d, yb_q, yb_d, z_q, z_d;
  logic [15:0]           mt_q, mt_d, mb_q, mb_d, mz_q, mz_d;
  logic                  neg_q, neg_d;
  logic [1:0]            color_q, color_d;
  logic [SCREEN_COLUMNS-1:0] valid_q, valid_d;
  res_t                  pend_q, pend_d;
  logic                  pend_v_q, pend_v_d;
  res_t                  res_q, res_d;
  logic                  strobe_q, strobe_d;

  logic [CW-1:0] col;
  logic [15:0]   ram_rdata;
  logic [15:0]   stored_z;
  logic          vis, ram_we;
  logic          guard_go, col_go;

  // Row of a y coordinate, clamped to the range 0 to SCREEN_ROWS
  function automatic logic [5:0] to_row(input logic [15:0] y);
    logic [15:0] off;
    off = y - LO16;
    if ({2'b00, y} < Y_LO) begin
      to_row = '0;
    end else if ({2'b00, y} > Y_HI) begin
      to_row = ROW_MX;
    end else begin
      to_row = off[13:8];
    end
  endfunction

  wcr_ram #(
    .WIDTH (16),
    .DEPTH (SCREEN_COLUMNS)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col),
    .wdata_i (z_q),
    .raddr_i (col),
    .rdata_o (ram_rdata)
  );

  // Loop conditions and depth test
  always_comb begin
    col      = x_q[8 +: CW];
    stored_z = valid_q[col] ? ram_rdata : DEPTH_INIT;
    vis      = z_q < stored_z;
    guard_go = (x_q[15:8] != tx_q[15:8]) &&
               (({1'b0, x_q} < X_LO) || ({1'b0, x_q} >= X_HI));
    col_go   = (x_q[15:8] != tx_q[15:8]) && ({1'b0, x_q[15:8]} < NCOL);
  end

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      B_IDLE: begin
        if (!qstat_i.empty && !job_i.clear) begin
          st_d = B_GUARD;
        end
      end
      B_GUARD: begin
        if (!guard_go) begin
          st_d = B_COL;
        end
      end
      B_COL:   st_d = col_go ? B_CMP : B_END;
      B_CMP:   st_d = B_COL;
      B_END:   st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    x_d      = x_q;
    tx_d     = tx_q;
    yt_d     = yt_q;
    yb_d     = yb_q;
    z_d      = z_q;
    mt_d     = mt_q;
    mb_d     = mb_q;
    mz_d     = mz_q;
    neg_d    = neg_q;
    color_d  = color_q;
    valid_d  = valid_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    res_d    = pend_q;
    strobe_d = 1'b0;
    pop_o    = 1'b0;
    ram_we   = 1'b0;
    case (st_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          if (job_i.clear) begin
            valid_d = '0;
          end else begin
            x_d     = job_i.x;
            tx_d    = job_i.vx;
            yt_d    = job_i.yt;
            yb_d    = job_i.yb;
            z_d     = job_i.z;
            mt_d    = job_i.mt;
            mb_d    = job_i.mb;
            mz_d    = job_i.mz;
            neg_d   = job_i.dir_neg;
            color_d = job_i.color;
          end
        end
      end
      B_GUARD: begin
        if (guard_go) begin
          x_d  = x_q + (neg_q ? STEP_NEG : STEP_POS);
          yt_d = yt_q + mt_q;
          yb_d = yb_q + mb_q;
          z_d  = z_q + mz_q;
        end else begin
          // switch to screen-relative x
          x_d  = x_q - LO16;
          tx_d = tx_q - LO16;
        end
      end
      B_CMP: begin
        if (vis) begin
          ram_we              = 1'b1;
          valid_d[col]        = 1'b1;
          strobe_d            = pend_v_q;
          pend_d.column       = x_q[13:8];
          pend_d.top_row      = to_row(yt_q);
          pend_d.bottom_row   = to_row(yb_q);
          pend_d.span_color   = color_q;
          pend_d.last         = 1'b0;
          pend_v_d            = 1'b1;
        end
        x_d  = x_q + (neg_q ? STEP_NEG : STEP_POS);
        yt_d = yt_q + mt_q;
        yb_d = yb_q + mb_q;
        z_d  = z_q + mz_q;
      end
      B_END: begin
        // held span is the final one of this draw
        strobe_d   = pend_v_q;
        res_d.last = 1'b1;
        pend_v_d   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= B_IDLE;
      valid_q  <= '0;
      pend_v_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      valid_q  <= valid_d;
      pend_v_q <= pend_v_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    tx_q    <= tx_d;
    yt_q    <= yt_d;
    yb_q    <= yb_d;
    z_q     <= z_d;
    mt_q    <= mt_d;
    mb_q    <= mb_d;
    mz_q    <= mz_d;
    neg_q   <= neg_d;
    color_q <= color_d;
    pend_q  <= pend_d;
    res_q   <= res_d;
  end

  assign result_o        = res_q;
  assign result_strobe_o = strobe_q;

endmodule
`default_nettype wire

/* hw/rtl/wall_column_rasterizer_zbuf_unit.sv */
// Wall column rasterizer with per-column depth store.
// Commands enter on cmd_i and transfer on a rising edge with start high and
// busy low. Mode 0 clears the depth store, mode 1 moves the pen, mode 2 draws
// a wall from the pen to the vertex, mode 3 is ignored.
// Each visible column of a draw gives one span on result_o, marked by
// result_strobe_o for one cycle; last flags the final span of a draw.
// The receiver cannot stall; spans never come back to back.
// Pen, clear and ignored commands leave the front idle. A draw first
// computes three slopes in the front, one quotient bit per cycle in a
// shared 24-step divider; then the back steps one guard-band column per
// cycle and takes each screen column through B_COL (depth RAM read), then
// B_CMP (compare and write), and ends in B_END. A two-entry queue lets the
// front compute the next draw's slopes while the back is still stepping.
// A span is held until the next visible column is tested or the draw ends,
// and appears in the cycle after that.
// Reset clears the pen to zero and marks every column depth as all ones;
// no clearing pass is needed.
`default_nettype none
module wall_column_rasterizer_zbuf_unit
  import wcr_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 64,
  parameter int SCREEN_ROWS    = 60,
  parameter int GUARD_OFFSET   = 16384
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd_i,
  output res_t      result_o,
  output logic      result_strobe_o
);

  fifo_stat_t       qstat;
  job_t             push_job, head_job;
  logic             push, pop;
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_quot;
  logic [15:0]      div_divisor;

  wcr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .cmd_i          (cmd_i),
    .busy_o         (busy),
    .qstat_i        (qstat),
    .push_o         (push),
    .job_o          (push_job),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot)
  );

  wcr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  wcr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .pop_i  (pop),
    .data_o (head_job),
    .stat_o (qstat)
  );

  wcr_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .GUARD_OFFSET   (GUARD_OFFSET)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .qstat_i         (qstat),
    .job_i           (head_job),
    .pop_o           (pop),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o)
  );

endmodule
`default_nettype wire

/* hw/rtl/wcr_checker.sv */
`default_nettype none
`include "wall_column_rasterizer_zbuf_unit_assert.svh"
module wcr_checker
  import wcr_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 64
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire cmd_t cmd_i,
  input wire res_t result_o,
  input wire logic result_strobe_o
);

  // spans never come in adjacent cycles
  `WCR_ASSERT_NEXT(a_strobe_gap, result_strobe_o, !result_strobe_o, "back-to-back spans")

  // a pen move or ignored command never makes the block busy
  `WCR_ASSERT_NEXT(a_pen_free, start && !busy && (cmd_i.mode == MODE_PEN || cmd_i.mode == MODE_NONE), !busy, "busy after pen command")

  // emitted column lies on screen
  `WCR_ASSERT_NOW(a_col_range, result_strobe_o, int'(result_o.column) < SCREEN_COLUMNS, "column off screen")

endmodule

bind wall_column_rasterizer_zbuf_unit wcr_checker #(
  .SCREEN_COLUMNS (SCREEN_COLUMNS)
) u_wcr_checker (.*);
`default_nettype wire
